[hw/rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared constants, types and round functions.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned WordDepth  = 16;
  localparam int unsigned LenWidth   = 61;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_RUN,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Phases of the round core.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOAD,
    PH_ROUND,
    PH_ADD
  } phase_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

[hw/rtl/sha_stream_if.sv]
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;
  modport source (output valid, digest_word, last_word, input ready);
  modport sink (input valid, digest_word, last_word, output ready);
endinterface
`default_nettype wire

[hw/rtl/sha_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Read before write: read data is registered and shows the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/sha_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds over a 16-word block memory, one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        init,
  output logic             busy,
  output logic             done,
  // block memory read port
  output logic [3:0]       w_raddr,
  input  wire logic [31:0] w_rdata,
  input  wire logic [2:0]  hsel,
  output logic [31:0]      hword
);
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [6:0]  cnt;
  sha_pkg::phase_t phase, phase_next;
  logic [31:0] wi, s0, s1, t1, t2;
  logic [5:0]  ridx;

  assign ridx = cnt[5:0];
  // Read address runs one ahead of the round counter: word 0 is fetched in
  // the load cycle and word r+1 during round r.
  assign w_raddr = (phase == sha_pkg::PH_ROUND) ? cnt[3:0] + 4'd1 : 4'd0;
  assign busy = (phase != sha_pkg::PH_IDLE);
  assign hword = h[hsel];

  // Message schedule word and the two round sums for this round.
  always_comb begin
    s0 = sha_pkg::rotr(w[1], 7) ^ sha_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha_pkg::rotr(w[14], 17) ^ sha_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wi = (ridx < 6'd16) ? w_rdata : (s1 + w[9] + s0 + w[0]);
    t1 = v[7] + (sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11) ^ sha_pkg::rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(ridx) + wi;
    t2 = (sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13) ^ sha_pkg::rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Phase sequence: load covers the memory read latency, then 64 rounds,
  // then the add into the hash words.
  always_comb begin
    phase_next = phase;
    case (phase)
      sha_pkg::PH_IDLE: begin
        if (start) phase_next = sha_pkg::PH_LOAD;
      end
      sha_pkg::PH_LOAD: begin
        phase_next = sha_pkg::PH_ROUND;
      end
      sha_pkg::PH_ROUND: begin
        if (cnt == 7'd63) phase_next = sha_pkg::PH_ADD;
      end
      default: phase_next = sha_pkg::PH_IDLE;
    endcase
  end

  // Round datapath and hash words.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sha_pkg::PH_IDLE;
      cnt <= '0;
      done <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= sha_pkg::init_hash(3'(i));
    end else begin
      phase <= phase_next;
      done <= (phase == sha_pkg::PH_ADD);
      if (init) begin
        for (int i = 0; i < 8; i++) h[i] <= sha_pkg::init_hash(3'(i));
      end
      case (phase)
        sha_pkg::PH_IDLE: begin
          if (start) begin
            cnt <= '0;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
          end
        end
        sha_pkg::PH_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wi;
          v[0] <= t1 + t2; v[1] <= v[0]; v[2] <= v[1]; v[3] <= v[2];
          v[4] <= v[3] + t1; v[5] <= v[4]; v[6] <= v[5]; v[7] <= v[6];
          cnt <= cnt + 7'd1;
        end
        sha_pkg::PH_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with block store in RAM and a round-serial core.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_ch: one message byte (byte_present) and/or the
//   end_of_message mark. Results leave on out_ch as eight 32-bit digest
//   words, word 0 first, last_word set on the eighth.
//   A byte that does not fill the block leaves the hasher ready for the next
//   request. The 64th byte of a block starts a compression in the round core
//   (load, 64 rounds, add and hand-back); no request is taken until it is
//   handed back. An end request writes the pad byte, zero fill and length one
//   byte per cycle into the block RAM up to byte 63, then compresses and emits
//   the digest. A tail of 56 bytes or more needs a second padded block and
//   compression; an end that comes with the 64th byte first waits for that
//   full block to be compressed. The words go out one per cycle while the
//   receiver is ready. A stall holds the current word and blocks new
//   requests until all eight are taken. Reset loads the initial hash values
//   and clears the byte count; the block RAM is not cleared, since every
//   byte is written before read.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher (
  input wire logic  clk,
  input wire logic  rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  sha_pkg::state_t state, state_next;
  logic [sha_pkg::LenWidth-1:0] len;
  logic [5:0]  pos;         // pad position in bytes
  logic [2:0]  word_idx;
  logic        second;      // a second compression follows
  logic        pending_end, fin_block;
  logic        we;
  logic [5:0]  waddr;
  logic [7:0]  wdata;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  logic        core_start, core_done, core_busy, core_init;
  logic [31:0] hword;
  logic        acc;
  logic [63:0] bits;
  logic [7:0]  lane_rd [4];

  assign acc = in_ch.valid && in_ch.ready;
  assign bits = {len, 3'b000};

  // Four byte lanes make up one block word; each lane is one RAM.
  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [7:0] lrd;
    sha_ram #(.Width(8), .Depth(sha_pkg::WordDepth)) u_ram (
      .clk(clk), .we(we && (waddr[1:0] == 2'(g))), .waddr(waddr[5:2]), .wdata(wdata),
      .raddr(raddr), .rdata(lrd));
    assign lane_rd[g] = lrd;
  end
  assign rdata = {lane_rd[0], lane_rd[1], lane_rd[2], lane_rd[3]};

  sha_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .init(core_init), .busy(core_busy),
    .done(core_done), .w_raddr(raddr), .w_rdata(rdata), .hsel(word_idx), .hword(hword));

  // Next state, handshakes, core control and byte-store writes.
  always_comb begin
    state_next = state;
    in_ch.ready = 1'b0;
    we = 1'b0;
    waddr = pos;
    wdata = 8'h00;
    core_start = 1'b0;
    core_init = 1'b0;
    out_ch.valid = 1'b0;
    case (state)
      sha_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        waddr = len[5:0];
        wdata = in_ch.data_byte;
        we = acc && in_ch.byte_present;
        if (acc && in_ch.byte_present && len[5:0] == 6'd63) begin
          core_start = 1'b1;
          state_next = sha_pkg::ST_RUN;
        end else if (acc && in_ch.end_of_message) begin
          state_next = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_PAD: begin
        we = 1'b1;
        // The pad byte goes in only on the first pass after the message.
        wdata = (pos == len[5:0] && !second) ? sha_pkg::PadByte : 8'h00;
        if (pos == 6'd63) begin
          core_start = 1'b1;
          state_next = sha_pkg::ST_RUN;
        end else if (pos == 6'd55) begin
          state_next = sha_pkg::ST_LEN;
        end
      end
      sha_pkg::ST_LEN: begin
        we = 1'b1;
        wdata = bits[8*(63-pos) +: 8];
        if (pos == 6'd63) begin
          core_start = 1'b1;
          state_next = sha_pkg::ST_RUN;
        end
      end
      sha_pkg::ST_RUN: begin
        if (core_done) state_next = sha_pkg::ST_ADD;
      end
      sha_pkg::ST_ADD: begin
        // After a compression: emit, continue padding, or resume the stream.
        if (fin_block) begin
          state_next = sha_pkg::ST_EMIT;
        end else if (pending_end) begin
          state_next = sha_pkg::ST_PAD;
        end else begin
          state_next = sha_pkg::ST_IDLE;
        end
      end
      sha_pkg::ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready && word_idx == 3'd7) begin
          core_init = 1'b1;
          state_next = sha_pkg::ST_IDLE;
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  assign out_ch.digest_word = hword;
  assign out_ch.last_word = (word_idx == 3'd7);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      len <= '0;
      pos <= '0;
      word_idx <= '0;
      second <= 1'b0;
      pending_end <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        sha_pkg::ST_IDLE: begin
          second <= 1'b0;
          pending_end <= acc && in_ch.end_of_message;
          if (acc && in_ch.byte_present) len <= len + 1'b1;
          if (acc) begin
            pos <= in_ch.byte_present ? len[5:0] + 6'd1 : len[5:0];
          end
        end
        sha_pkg::ST_PAD, sha_pkg::ST_LEN: begin
          pos <= pos + 6'd1;
          if (pos == 6'd63 && state == sha_pkg::ST_PAD) second <= 1'b1;
        end
        sha_pkg::ST_ADD: begin
          // Restart the digest index or the pad position for what follows.
          if (fin_block) begin
            word_idx <= '0;
          end else if (pending_end) begin
            pos <= '0;
          end
        end
        sha_pkg::ST_EMIT: begin
          if (out_ch.ready) begin
            word_idx <= word_idx + 3'd1;
            if (word_idx == 3'd7) len <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Track whether the block in the core is the final one of a message.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_block <= 1'b0;
    end else if (core_start) begin
      fin_block <= (state == sha_pkg::ST_LEN) || (state == sha_pkg::ST_PAD && second);
    end
  end

  // A compression only starts from a pad, length or full-block step.
  assert property (@(posedge clk) disable iff (rst)
    core_start |-> !core_busy)
    else $error("compression started while core busy");
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("request taken during digest output");
  assert property (@(posedge clk) disable iff (rst)
    (state == sha_pkg::ST_EMIT && out_ch.ready && word_idx == 3'd7) |=> len == '0)
    else $error("length not cleared after digest");
endmodule
`default_nettype wire
